// ===== sv/pmscan_pkg.sv =====
// Shared types, marker table and sizing constants for the priority marker scanner.
package pmscan_pkg;

	localparam int NUM_MARKERS  = 4;
	localparam int HIST_DEPTH   = 15;
	localparam int MARK_WIDTH   = 16;
	localparam int MARK_IDX_W   = $clog2(MARK_WIDTH);
	localparam int MARK_SEL_W   = $clog2(NUM_MARKERS);
	localparam int LEN_W        = $clog2(MARK_WIDTH + 1);
	localparam int FILL_W       = $clog2(HIST_DEPTH + 1);
	localparam int TAIL_MAX_DEF = 32;

	typedef logic [7:0] char_t;
	typedef logic [MARK_SEL_W-1:0] mark_sel_t;
	typedef logic [LEN_W-1:0] mark_len_t;

	localparam char_t PRINT_LO = 8'h20;
	localparam char_t PRINT_HI = 8'h7E;
	localparam char_t NULL_CHAR = 8'h00;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_image;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       was_found;
		logic       out_last;
	} out_word_t;

	// Markers in priority order; unused trailing characters are zero.
	localparam char_t MARKER_TEXT [NUM_MARKERS][MARK_WIDTH] = '{
		'{8'h55, 8'h6E, 8'h72, 8'h65, 8'h61, 8'h6C, 8'h20, 8'h45,
		  8'h6E, 8'h67, 8'h69, 8'h6E, 8'h65, 8'h20, 8'h34, 8'h2E},
		'{8'h55, 8'h6E, 8'h72, 8'h65, 8'h61, 8'h6C, 8'h20, 8'h45,
		  8'h6E, 8'h67, 8'h69, 8'h6E, 8'h65, 8'h20, 8'h35, 8'h2E},
		'{8'h46, 8'h45, 8'h6E, 8'h67, 8'h69, 8'h6E, 8'h65, 8'h56,
		  8'h65, 8'h72, 8'h73, 8'h69, 8'h6F, 8'h6E, 8'h00, 8'h00},
		'{8'h45, 8'h6E, 8'h67, 8'h69, 8'h6E, 8'h65, 8'h56, 8'h65,
		  8'h72, 8'h73, 8'h69, 8'h6F, 8'h6E, 8'h00, 8'h00, 8'h00}
	};

	localparam mark_len_t MARKER_LEN [NUM_MARKERS] = '{5'd16, 5'd16, 5'd14, 5'd13};

endpackage

// ===== sv/priority_marker_scanner_core.sv =====
// Priority marker scanner: streaming marker match, per-marker tail capture and result emitter.
//
// Usage: image bytes enter on the scan channel (scan_valid/scan_ready/scan_word), one word per
// cycle; end_of_image flags the final byte. Every byte is compared against all four markers
// in parallel with a 15-byte history, and the first hit of each marker starts capture of up to
// TAIL_MAX printable bytes into that marker's own tail memory.
// When the final byte is accepted, the highest priority marker that was seen is emitted on the
// result channel (result_valid/result_ready/result_word): its characters, then its tail, one
// word per cycle, with out_last on the final word. With no hit a single not-found word is sent.
// After the final byte is accepted, the first result word passes the emitter state, stage 1 and
// stage 2 before it is valid. Throughput: one byte per cycle while scanning. After the final
// byte, scan_ready stays low while the emitter walks the result words (marker length plus tail,
// at most 16 + TAIL_MAX), reading each tail memory through its single read port.
// A stall on the result side holds the two-stage emit pipeline and with it the emitter; a new
// image may start as soon as the last result word has been issued.
// Reset (arst_n low) clears the hit, capture and fill state and empties the pipeline; the history
// and the tail memories are not cleared, only entries written in the current image are ever read.
module priority_marker_scanner_core
	import pmscan_pkg::*;
#(
	parameter int TAIL_MAX = TAIL_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      scan_valid,
	output logic      scan_ready,
	input  in_word_t  scan_word,
	output logic      result_valid,
	input  logic      result_ready,
	output out_word_t result_word
);

	localparam int CNT_W  = $clog2(TAIL_MAX + 1);
	localparam int ADDR_W = (TAIL_MAX > 1) ? $clog2(TAIL_MAX) : 1;
	localparam int TOT_W  = $clog2(MARK_WIDTH + TAIL_MAX + 1);

	// Scan state.
	char_t                   hist_q [HIST_DEPTH];
	logic [FILL_W-1:0]       fill_q;
	logic [NUM_MARKERS-1:0]  hit_q, active_q;
	logic [CNT_W-1:0]        count_q [NUM_MARKERS];
	logic [NUM_MARKERS-1:0]  hit_n, active_n, match, wr_en;
	logic [CNT_W-1:0]        count_n [NUM_MARKERS];
	char_t                   b;
	logic                    last_in, accept, printable;

	// Result selection.
	mark_sel_t               sel_m;
	logic                    any_hit;
	logic [TOT_W-1:0]        sel_total;

	// Emitter.
	logic                    busy_q, em_found_q;
	mark_sel_t               em_m_q;
	mark_len_t               em_len_q;
	logic [TOT_W-1:0]        em_total_q, em_idx_q;
	logic                    issue, from_mem, em_is_last;
	logic [ADDR_W-1:0]       rd_addr;
	char_t                   const_char;
	char_t                   rd_q [NUM_MARKERS];

	// Emit pipeline.
	logic                    valid_s1, from_mem_s1, found_s1, last_s1, adv_s1;
	char_t                   char_s1;
	mark_sel_t               m_s1;
	logic                    valid_s2;
	out_word_t               word_s2;

	assign b          = scan_word.data_byte;
	assign last_in    = scan_word.end_of_image;
	assign scan_ready = !busy_q;
	assign accept     = scan_valid && scan_ready;
	assign printable  = (b >= PRINT_LO) && (b <= PRINT_HI);

	// A marker ends on this byte when its last character matches the byte and the rest
	// matches the history, newest byte first.
	always_comb begin
		for (int m = 0; m < NUM_MARKERS; m++) begin
			match[m] = (fill_q >= FILL_W'(MARKER_LEN[m] - 1'b1))
				&& (b == MARKER_TEXT[m][MARK_IDX_W'(MARKER_LEN[m] - 1'b1)]);
			for (int k = 0; k < HIST_DEPTH; k++) begin
				if (k + 1 < int'(MARKER_LEN[m])) begin
					if (hist_q[k] != MARKER_TEXT[m][MARK_IDX_W'(int'(MARKER_LEN[m]) - 2 - k)]) begin
						match[m] = 1'b0;
					end
				end
			end
		end
	end

	always_comb begin
		for (int m = 0; m < NUM_MARKERS; m++) begin
			hit_n[m]    = hit_q[m];
			active_n[m] = active_q[m];
			count_n[m]  = count_q[m];
			wr_en[m]    = 1'b0;
			if (active_q[m]) begin
				if (printable && (count_q[m] < CNT_W'(TAIL_MAX))) begin
					wr_en[m]   = 1'b1;
					count_n[m] = count_q[m] + 1'b1;
					if (count_n[m] == CNT_W'(TAIL_MAX)) begin
						active_n[m] = 1'b0;
					end
				end else begin
					active_n[m] = 1'b0;
				end
			end
			// The tail of a new first occurrence starts with the next byte.
			if (!hit_q[m] && match[m]) begin
				hit_n[m]    = 1'b1;
				active_n[m] = 1'b1;
				count_n[m]  = '0;
			end
		end
	end

	always_comb begin
		sel_m = '0;
		for (int m = NUM_MARKERS - 1; m >= 0; m--) begin
			if (hit_n[m]) begin
				sel_m = MARK_SEL_W'(m);
			end
		end
	end

	assign any_hit   = |hit_n;
	assign sel_total = any_hit ? (TOT_W'(MARKER_LEN[sel_m]) + TOT_W'(count_n[sel_m])) : TOT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q    <= '0;
			active_q <= '0;
			fill_q   <= '0;
			for (int m = 0; m < NUM_MARKERS; m++) begin
				count_q[m] <= '0;
			end
		end else if (accept) begin
			if (last_in) begin
				hit_q    <= '0;
				active_q <= '0;
				fill_q   <= '0;
				for (int m = 0; m < NUM_MARKERS; m++) begin
					count_q[m] <= '0;
				end
			end else begin
				hit_q    <= hit_n;
				active_q <= active_n;
				if (fill_q != FILL_W'(HIST_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
				for (int m = 0; m < NUM_MARKERS; m++) begin
					count_q[m] <= count_n[m];
				end
			end
		end
	end

	// History entries beyond the fill count are never compared.
	always_ff @(posedge clk) begin
		if (accept) begin
			hist_q[0] <= b;
			for (int k = 1; k < HIST_DEPTH; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
	end

	assign adv_s1     = valid_s1 && (!valid_s2 || result_ready);
	assign issue      = busy_q && (!valid_s1 || adv_s1);
	assign from_mem   = em_found_q && (em_idx_q >= TOT_W'(em_len_q));
	assign rd_addr    = ADDR_W'(em_idx_q - TOT_W'(em_len_q));
	assign const_char = em_found_q ? MARKER_TEXT[em_m_q][em_idx_q[MARK_IDX_W-1:0]] : NULL_CHAR;
	assign em_is_last = (TOT_W'(em_idx_q + 1'b1) == em_total_q);

	for (genvar gm = 0; gm < NUM_MARKERS; gm++) begin : g_tail
		char_t tail_mem [TAIL_MAX];

		always_ff @(posedge clk) begin
			if (accept && wr_en[gm]) begin
				tail_mem[count_q[gm][ADDR_W-1:0]] <= b;
			end
			if (issue && from_mem) begin
				rd_q[gm] <= tail_mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			em_found_q <= 1'b0;
			em_m_q     <= '0;
			em_len_q   <= '0;
			em_total_q <= '0;
			em_idx_q   <= '0;
		end else if (accept && last_in) begin
			busy_q     <= 1'b1;
			em_found_q <= any_hit;
			em_m_q     <= sel_m;
			em_len_q   <= any_hit ? MARKER_LEN[sel_m] : '0;
			em_total_q <= sel_total;
			em_idx_q   <= '0;
		end else if (issue) begin
			em_idx_q <= em_idx_q + 1'b1;
			if (em_is_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// The tail byte is read at issue and lands in rd_q together with the stage 1 word.
	always_ff @(posedge clk) begin
		if (issue) begin
			char_s1     <= const_char;
			from_mem_s1 <= from_mem;
			found_s1    <= em_found_q;
			last_s1     <= em_is_last;
			m_s1        <= em_m_q;
		end
		if (adv_s1) begin
			word_s2.out_char  <= from_mem_s1 ? rd_q[m_s1] : char_s1;
			word_s2.was_found <= found_s1;
			word_s2.out_last  <= last_s1;
		end
	end

	assign result_valid = valid_s2;
	assign result_word  = word_s2;

`ifndef SYNTHESIS
	a_last_starts_emit: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_in |=> busy_q)
		else $error("final byte did not start result emission");

	a_tail_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q & ~hit_q) == '0)
		else $error("tail capture active for a marker that never matched");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> em_idx_q < em_total_q)
		else $error("emit index ran past the result length");

	a_not_found_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_word.was_found |->
			result_word.out_last && result_word.out_char == NULL_CHAR)
		else $error("not-found result is not a single zero word");
`endif

endmodule
